### src/uritp_pkg.sv
// shared types and constants of the uri template expression parser
// no dependencies; used by every module of the block but uritp_fifo

package uritp_pkg;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UZ     = 8'h5A;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_PLUS  = 3'd1;
    localparam logic [2:0] OP_HASH  = 3'd2;
    localparam logic [2:0] OP_DOT   = 3'd3;
    localparam logic [2:0] OP_SLASH = 3'd4;
    localparam logic [2:0] OP_SEMI  = 3'd5;
    localparam logic [2:0] OP_QUEST = 3'd6;
    localparam logic [2:0] OP_AMP   = 3'd7;

    localparam int PREFIX_MAX = 9999;

    typedef struct packed {
        logic       term;
        logic       last;
        logic       pct;
        logic       colon;
        logic       star;
        logic       name_ok;
        logic       hex;
        logic       digit;
        logic       nz_digit;
        logic [3:0] value;
        logic [2:0] op;
    } cls_t;

    typedef struct packed {
        logic [7:0]  name_len;
        logic [13:0] prefix_len;
        logic        explode;
        logic [2:0]  op_code;
        logic        expr_error;
        logic        last_var;
    } rec_t;

endpackage

### src/uritp_classify.sv
// front end: sorts each input byte into the character classes the parser needs
// depends on uritp_pkg

module uritp_classify
    import uritp_pkg::*;
(
    input  logic [7:0] ch,
    output cls_t       cls
);

    logic is_dig;
    logic is_lo;
    logic is_up;

    always_comb
    begin
        is_dig = (ch >= CH_0) && (ch <= CH_9);
        is_lo  = (ch >= CH_LA) && (ch <= CH_LZ);
        is_up  = (ch >= CH_UA) && (ch <= CH_UZ);

        cls.term     = (ch == CH_COMMA) || (ch == CH_RBRACE);
        cls.last     = (ch == CH_RBRACE);
        cls.pct      = (ch == CH_PCT);
        cls.colon    = (ch == CH_COLON);
        cls.star     = (ch == CH_STAR);
        cls.name_ok  = is_dig || is_lo || is_up || (ch == CH_UNDER) || (ch == CH_DOT);
        cls.hex      = is_dig || ((ch >= CH_LA) && (ch <= CH_LF))
                       || ((ch >= CH_UA) && (ch <= CH_UF));
        cls.digit    = is_dig;
        cls.nz_digit = (ch >= CH_1) && (ch <= CH_9);
        cls.value    = ch[3:0];

        unique case (ch)
            CH_PLUS:  cls.op = OP_PLUS;
            CH_HASH:  cls.op = OP_HASH;
            CH_DOT:   cls.op = OP_DOT;
            CH_SLASH: cls.op = OP_SLASH;
            CH_SEMI:  cls.op = OP_SEMI;
            CH_QUEST: cls.op = OP_QUEST;
            CH_AMP:   cls.op = OP_AMP;
            default:  cls.op = OP_NONE;
        endcase
    end

endmodule

### src/uritp_fifo.sv
// small register queue used between front and back and at the result side
// no dependencies

module uritp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/uritp_parse.sv
// back end: expression state machine, one classified byte per beat, builds records
// depends on uritp_pkg

module uritp_parse
    import uritp_pkg::*;
#(
    parameter int NAME_LEN_BITS = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  cls_t cls,
    output logic rec_valid,
    output rec_t rec
);

    localparam int CNT_W = (NAME_LEN_BITS < 8) ? NAME_LEN_BITS : 8;
    localparam logic [2:0] MAX_DIGITS  = 3'd4;
    localparam logic [2:0] DIGITS_OVER = 3'd5;

    typedef enum logic [2:0] {
        PH_START,
        PH_NAME,
        PH_HEX,
        PH_PFX_FIRST,
        PH_PFX_DIGITS,
        PH_STAR,
        PH_SKIP
    } phase_t;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [2:0]       op_reg;
    logic [2:0]       op_next;
    logic             err_reg;
    logic             err_next;
    logic [CNT_W-1:0] name_count_reg;
    logic [CNT_W-1:0] name_count_next;
    logic [13:0]      prefix_acc_reg;
    logic [13:0]      prefix_acc_next;
    logic [2:0]       digit_count_reg;
    logic [2:0]       digit_count_next;
    logic             explode_reg;
    logic             explode_next;
    logic [1:0]       hex_left_reg;
    logic [1:0]       hex_left_next;
    logic             do_name;
    logic             do_emit;
    logic             count_inc;

    always_comb
    begin
        phase_next       = phase_reg;
        op_next          = op_reg;
        err_next         = err_reg;
        name_count_next  = name_count_reg;
        prefix_acc_next  = prefix_acc_reg;
        digit_count_next = digit_count_reg;
        explode_next     = explode_reg;
        hex_left_next    = hex_left_reg;
        do_name          = 1'b0;
        do_emit          = 1'b0;
        count_inc        = 1'b0;
        rec              = '0;

        unique case (phase_reg)
            PH_START:
            begin
                if (cls.op != OP_NONE)
                begin
                    op_next    = cls.op;
                    phase_next = PH_NAME;
                end
                else
                begin
                    do_name = 1'b1;
                end
            end
            PH_HEX:
            begin
                if (cls.hex)
                begin
                    count_inc     = 1'b1;
                    hex_left_next = hex_left_reg - 1'b1;
                    if (hex_left_reg == 2'd1)
                    begin
                        phase_next = PH_NAME;
                    end
                end
                else
                begin
                    err_next      = 1'b1;
                    hex_left_next = '0;
                    do_name       = 1'b1;
                end
            end
            PH_PFX_FIRST:
            begin
                if (cls.nz_digit)
                begin
                    prefix_acc_next  = 14'(cls.value);
                    digit_count_next = 3'd1;
                    phase_next       = PH_PFX_DIGITS;
                end
                else
                begin
                    err_next        = 1'b1;
                    prefix_acc_next = '0;
                    if (cls.term)
                    begin
                        do_emit = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_PFX_DIGITS:
            begin
                if (cls.digit)
                begin
                    if (digit_count_reg < MAX_DIGITS)
                    begin
                        prefix_acc_next  = 14'({prefix_acc_reg, 3'b000})
                                           + 14'({prefix_acc_reg, 1'b0})
                                           + 14'(cls.value);
                        digit_count_next = digit_count_reg + 1'b1;
                    end
                    else
                    begin
                        err_next         = 1'b1;
                        prefix_acc_next  = '0;
                        digit_count_next = DIGITS_OVER;
                    end
                end
                else if (cls.term)
                begin
                    do_emit = 1'b1;
                end
                else
                begin
                    err_next        = 1'b1;
                    prefix_acc_next = '0;
                    phase_next      = PH_SKIP;
                end
            end
            PH_STAR:
            begin
                if (cls.term)
                begin
                    explode_next = 1'b1;
                    do_emit      = 1'b1;
                end
                else
                begin
                    err_next   = 1'b1;
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (cls.term)
                begin
                    do_emit = 1'b1;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            default:
            begin
                do_name = 1'b1;
            end
        endcase

        // ordinary name byte handling
        if (do_name)
        begin
            phase_next = PH_NAME;
            if (cls.term)
            begin
                do_emit = 1'b1;
            end
            else if (cls.pct)
            begin
                count_inc     = 1'b1;
                hex_left_next = 2'd2;
                phase_next    = PH_HEX;
            end
            else if (cls.colon)
            begin
                phase_next = PH_PFX_FIRST;
            end
            else if (cls.star)
            begin
                phase_next = PH_STAR;
            end
            else
            begin
                if (!cls.name_ok)
                begin
                    err_next = 1'b1;
                end
                count_inc = 1'b1;
            end
        end

        // saturating name length
        if (count_inc && (name_count_reg != '1))
        begin
            name_count_next = name_count_reg + 1'b1;
        end

        if (do_emit)
        begin
            rec.name_len     = 8'(name_count_next);
            rec.prefix_len   = prefix_acc_next;
            rec.explode      = explode_next;
            rec.op_code      = op_next;
            rec.expr_error   = err_next;
            rec.last_var     = cls.last;
            name_count_next  = '0;
            prefix_acc_next  = '0;
            digit_count_next = '0;
            explode_next     = 1'b0;
            hex_left_next    = '0;
            if (cls.last)
            begin
                phase_next = PH_START;
                op_next    = OP_NONE;
                err_next   = 1'b0;
            end
            else
            begin
                phase_next = PH_NAME;
            end
        end
    end

    assign rec_valid = fire && do_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            op_reg          <= OP_NONE;
            err_reg         <= 1'b0;
            name_count_reg  <= '0;
            prefix_acc_reg  <= '0;
            digit_count_reg <= '0;
            explode_reg     <= 1'b0;
            hex_left_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            op_reg          <= op_next;
            err_reg         <= err_next;
            name_count_reg  <= name_count_next;
            prefix_acc_reg  <= prefix_acc_next;
            digit_count_reg <= digit_count_next;
            explode_reg     <= explode_next;
            hex_left_reg    <= hex_left_next;
        end
    end

endmodule

### src/uri_template_expression_parser_core.sv
// Streaming parser for the body of one URI template expression.
// Input channel: push/full, one byte of the expression body per beat on ch,
// the body closed by a right brace. A beat is taken when push is high and
// full is low.
// Result channel: empty/pop. Each comma or right brace yields one variable
// record (name_len, prefix_len, explode, op_code, expr_error, last_var);
// other bytes yield none. The oldest record sits on the ports while empty
// is low and leaves on a clock edge with pop high.
// A byte passes the front queue, the back end and then the result queue.
// Throughput: one byte per cycle while the result queue has room, set by the
// state update in the back end; the front queue and the result queue each hold
// two beats. When the result queue fills, the back end stops, the front queue
// fills and full rises; nothing is dropped.
// Reset (rst_n low, asynchronous) empties both queues and returns the parser
// to the start of an expression.
// depends on uritp_pkg, uritp_classify, uritp_fifo, uritp_parse

module uri_template_expression_parser_core
    import uritp_pkg::*;
#(
    parameter int NAME_LEN_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  ch,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  name_len,
    output logic [13:0] prefix_len,
    output logic        explode,
    output logic [2:0]  op_code,
    output logic        expr_error,
    output logic        last_var
);

    localparam int QUEUE_DEPTH = 2;

    cls_t in_cls;
    cls_t mid_cls;
    logic mid_empty;
    logic out_full;
    logic fire;
    logic rec_valid;
    rec_t rec;
    rec_t out_rec;

    uritp_classify u_classify (
        .ch  (ch),
        .cls (in_cls)
    );

    uritp_fifo #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_cls),
        .rd_en   (fire),
        .rd_data (mid_cls),
        .full    (full),
        .empty   (mid_empty)
    );

    assign fire = !mid_empty && !out_full;

    uritp_parse #(
        .NAME_LEN_BITS (NAME_LEN_BITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .cls       (mid_cls),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    uritp_fifo #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_data (rec),
        .rd_en   (pop),
        .rd_data (out_rec),
        .full    (out_full),
        .empty   (empty)
    );

    assign name_len   = out_rec.name_len;
    assign prefix_len = out_rec.prefix_len;
    assign explode    = out_rec.explode;
    assign op_code    = out_rec.op_code;
    assign expr_error = out_rec.expr_error;
    assign last_var   = out_rec.last_var;

endmodule

### src/uritp_checker.sv
// port-level checks on the parser's result channel, bound to the top level
// depends on uritp_pkg and uri_template_expression_parser_core

module uritp_checker
    import uritp_pkg::*;
#(
    parameter int NAME_LEN_BITS = 8
) (
    input logic        clk,
    input logic        rst_n,
    input logic        pop,
    input logic        empty,
    input logic [7:0]  name_len,
    input logic [13:0] prefix_len,
    input logic        explode,
    input logic [2:0]  op_code,
    input logic        expr_error,
    input logic        last_var
);

    localparam int CNT_W = (NAME_LEN_BITS < 8) ? NAME_LEN_BITS : 8;
    localparam logic [7:0] NAME_MAX = 8'((1 << CNT_W) - 1);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(name_len) && $stable(prefix_len)
                              && $stable(explode) && $stable(op_code)
                              && $stable(expr_error) && $stable(last_var)))
        else $error("result beat changed while stalled");

    // star and prefix modifiers exclude each other
    a_mod_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && explode) |-> (prefix_len == '0))
        else $error("explode with nonzero prefix");

    a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (prefix_len <= 14'(PREFIX_MAX)))
        else $error("prefix value out of range");

    a_name_sat: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (name_len <= NAME_MAX))
        else $error("name length above saturation limit");

endmodule

bind uri_template_expression_parser_core uritp_checker #(
    .NAME_LEN_BITS (NAME_LEN_BITS)
) u_uritp_checker (.*);

### test/uritp_check.sv
// checker for the uri template expression parser: follows the byte and record beats,
// parses the byte stream on its own and compares each variable record field by field
// depends on uritp_pkg

module uritp_check
    import uritp_pkg::*;
#(
    parameter int NAME_LEN_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  ch,
    input  logic        pop,
    input  logic        empty,
    input  logic [7:0]  name_len,
    input  logic [13:0] prefix_len,
    input  logic        explode,
    input  logic [2:0]  op_code,
    input  logic        expr_error,
    input  logic        last_var,
    output int          mismatches,
    output int          waiting
);

    typedef enum logic [2:0] {
        ST_OPEN,
        ST_NAME,
        ST_PCT,
        ST_PFX_FIRST,
        ST_PFX_MORE,
        ST_STAR,
        ST_SKIP
    } scan_t;

    localparam int NAME_CAP =
        ((1 << NAME_LEN_BITS) - 1) > 255 ? 255 : (1 << NAME_LEN_BITS) - 1;
    localparam logic [2:0] PFX_DIGITS_MAX = 3'd4;
    localparam logic [2:0] PFX_DIGITS_OVER = 3'd5;

    scan_t       scan_ph;
    logic [2:0]  op_sel;
    logic        err_seen;
    logic [7:0]  name_cnt;
    logic [13:0] pfx_val;
    logic [2:0]  pfx_digits;
    logic        star_ok;
    logic [1:0]  hex_due;
    rec_t        records_due[$];
    rec_t        got;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_hexdig(input logic [7:0] c);
        return is_digit(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic is_namech(input logic [7:0] c);
        return is_digit(c) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ)
            || c == CH_UNDER || c == CH_DOT;
    endfunction

    function automatic logic [2:0] op_for(input logic [7:0] c);
        case (c)
            CH_PLUS:  return OP_PLUS;
            CH_HASH:  return OP_HASH;
            CH_DOT:   return OP_DOT;
            CH_SLASH: return OP_SLASH;
            CH_SEMI:  return OP_SEMI;
            CH_QUEST: return OP_QUEST;
            CH_AMP:   return OP_AMP;
            default:  return OP_NONE;
        endcase
    endfunction

    task automatic clear_parse();
        scan_ph = ST_OPEN;
        op_sel = OP_NONE;
        err_seen = 1'b0;
        name_cnt = '0;
        pfx_val = '0;
        pfx_digits = '0;
        star_ok = 1'b0;
        hex_due = '0;
    endtask

    task automatic bump_name();
        if (name_cnt < NAME_CAP)
        begin
            name_cnt++;
        end
    endtask

    task automatic close_var(input logic [7:0] c);
        rec_t r;
        r.name_len = name_cnt;
        r.prefix_len = pfx_val;
        r.explode = star_ok;
        r.op_code = op_sel;
        r.expr_error = err_seen;
        r.last_var = (c == CH_RBRACE);
        records_due.push_back(r);
        if (r.last_var)
        begin
            clear_parse();
        end
        else
        begin
            name_cnt = '0;
            pfx_val = '0;
            pfx_digits = '0;
            star_ok = 1'b0;
            hex_due = '0;
            scan_ph = ST_NAME;
        end
    endtask

    task automatic name_char(input logic [7:0] c);
        scan_ph = ST_NAME;
        if (c == CH_COMMA || c == CH_RBRACE)
        begin
            close_var(c);
        end
        else if (c == CH_PCT)
        begin
            bump_name();
            hex_due = 2'd2;
            scan_ph = ST_PCT;
        end
        else if (c == CH_COLON)
        begin
            scan_ph = ST_PFX_FIRST;
        end
        else if (c == CH_STAR)
        begin
            scan_ph = ST_STAR;
        end
        else
        begin
            if (!is_namech(c))
            begin
                err_seen = 1'b1;
            end
            bump_name();
        end
    endtask

    task automatic parse_byte(input logic [7:0] c);
        logic term;
        term = (c == CH_COMMA || c == CH_RBRACE);
        case (scan_ph)
            ST_OPEN:
            begin
                if (op_for(c) != OP_NONE)
                begin
                    op_sel = op_for(c);
                    scan_ph = ST_NAME;
                end
                else
                begin
                    name_char(c);
                end
            end
            ST_PCT:
            begin
                if (is_hexdig(c))
                begin
                    bump_name();
                    if (hex_due != 0)
                    begin
                        hex_due--;
                    end
                    if (hex_due == 0)
                    begin
                        scan_ph = ST_NAME;
                    end
                end
                else
                begin
                    err_seen = 1'b1;
                    hex_due = '0;
                    name_char(c);
                end
            end
            ST_PFX_FIRST:
            begin
                if (c >= CH_1 && c <= CH_9)
                begin
                    pfx_val = 14'(c - CH_0);
                    pfx_digits = 3'd1;
                    scan_ph = ST_PFX_MORE;
                end
                else
                begin
                    err_seen = 1'b1;
                    pfx_val = '0;
                    if (term)
                    begin
                        close_var(c);
                    end
                    else
                    begin
                        scan_ph = ST_SKIP;
                    end
                end
            end
            ST_PFX_MORE:
            begin
                if (is_digit(c))
                begin
                    if (pfx_digits < PFX_DIGITS_MAX)
                    begin
                        pfx_val = pfx_val * 14'd10 + 14'(c - CH_0);
                        pfx_digits++;
                    end
                    else
                    begin
                        err_seen = 1'b1;
                        pfx_val = '0;
                        pfx_digits = PFX_DIGITS_OVER;
                    end
                end
                else if (term)
                begin
                    close_var(c);
                end
                else
                begin
                    err_seen = 1'b1;
                    pfx_val = '0;
                    scan_ph = ST_SKIP;
                end
            end
            ST_STAR:
            begin
                if (term)
                begin
                    star_ok = 1'b1;
                    close_var(c);
                end
                else
                begin
                    err_seen = 1'b1;
                    scan_ph = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (term)
                begin
                    close_var(c);
                end
                else
                begin
                    err_seen = 1'b1;
                end
            end
            default:
            begin
                name_char(c);
            end
        endcase
    endtask

    task automatic report(input string what, input logic [13:0] want, input logic [13:0] seen);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s mismatch: expected %0d, got %0d", what, want, seen);
        end
    endtask

    task automatic check_record();
        rec_t want;
        if (records_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("record beat with no record expected: %h", got);
            end
        end
        else
        begin
            want = records_due.pop_front();
            if (got.name_len !== want.name_len)
                report("name_len", want.name_len, got.name_len);
            if (got.prefix_len !== want.prefix_len)
                report("prefix_len", want.prefix_len, got.prefix_len);
            if (got.explode !== want.explode)
                report("explode", want.explode, got.explode);
            if (got.op_code !== want.op_code)
                report("op_code", want.op_code, got.op_code);
            if (got.expr_error !== want.expr_error)
                report("expr_error", want.expr_error, got.expr_error);
            if (got.last_var !== want.last_var)
                report("last_var", want.last_var, got.last_var);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            records_due.delete();
            mismatches = 0;
            waiting <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got = {name_len, prefix_len, explode, op_code, expr_error, last_var};
                check_record();
            end
            if (push && !full)
            begin
                parse_byte(ch);
            end
            waiting <= records_due.size();
        end
    end

endmodule

### test/tb.sv
// testbench top for uri_template_expression_parser_core: feeds directed and random
// expression bodies under several idle patterns and gives the verdict
// depends on uritp_pkg, uritp_check and the parser rtl

module tb;
    import uritp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BEATS = 360;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  ch;
    logic        pop;
    logic        empty;
    logic [7:0]  name_len;
    logic [13:0] prefix_len;
    logic        explode;
    logic [2:0]  op_code;
    logic        expr_error;
    logic        last_var;
    int          mismatches;
    int          waiting;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          quiet = 0;
    logic [7:0]  text[$];

    uri_template_expression_parser_core uut (.*);

    uritp_check chk (.*);

    always #4 clk = ~clk;

    initial
    begin
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            pop <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet <= 0;
        end
        else if (quiet >= STALL_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [7:0] digit_ch(input int d);
        return CH_0 + 8'(d);
    endfunction

    function automatic logic [7:0] hex_ch();
        int r;
        r = $urandom_range(21);
        if (r < 10)
            return digit_ch(r);
        if (r < 16)
            return CH_LA + 8'(r - 10);
        return CH_UA + 8'(r - 16);
    endfunction

    function automatic logic [7:0] op_ch(input int k);
        case (k)
            0:       return CH_PLUS;
            1:       return CH_HASH;
            2:       return CH_DOT;
            3:       return CH_SLASH;
            4:       return CH_SEMI;
            5:       return CH_QUEST;
            default: return CH_AMP;
        endcase
    endfunction

    function automatic logic [7:0] noise_ch();
        if ($urandom_range(1))
            return 8'($urandom_range(255));
        case ($urandom_range(9))
            0:       return CH_PCT;
            1:       return CH_COLON;
            2:       return CH_STAR;
            3:       return CH_COMMA;
            4:       return CH_RBRACE;
            5:       return CH_0;
            6:       return CH_1;
            7:       return CH_9;
            8:       return CH_UNDER;
            default: return op_ch($urandom_range(6));
        endcase
    endfunction

    task automatic add_expr(input bit long_name);
        int nv;
        int len;
        int mark;
        int r;
        mark = text.size();
        if ($urandom_range(99) < 80)
        begin
            if ($urandom_range(1))
                text.push_back(op_ch($urandom_range(6)));
            nv = $urandom_range(1, 3);
            for (int v = 0; v < nv; v++)
            begin
                len = (long_name && v == 0) ? $urandom_range(260, 280) : $urandom_range(0, 6);
                repeat (len)
                begin
                    r = $urandom_range(9);
                    if (r < 6)
                    begin
                        r = $urandom_range(61);
                        if (r < 10)
                            text.push_back(digit_ch(r));
                        else if (r < 36)
                            text.push_back(CH_LA + 8'(r - 10));
                        else
                            text.push_back(CH_UA + 8'(r - 36));
                    end
                    else if (r == 6)
                        text.push_back(CH_UNDER);
                    else if (r == 7)
                        text.push_back(CH_DOT);
                    else
                        text = {text, CH_PCT, hex_ch(), hex_ch()};
                end
                case ($urandom_range(3))
                    1:
                    begin
                        text = {text, CH_COLON, digit_ch($urandom_range(1, 9))};
                        repeat (($urandom_range(9) == 0) ? $urandom_range(4, 5)
                                                          : $urandom_range(0, 3))
                            text.push_back(digit_ch($urandom_range(9)));
                    end
                    2: text.push_back(CH_STAR);
                    default: ;
                endcase
                text.push_back(v == nv - 1 ? CH_RBRACE : CH_COMMA);
            end
            if ($urandom_range(99) < 30 && text.size() - mark > 1)
                text[$urandom_range(mark, text.size() - 2)] = noise_ch();
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                text.push_back(noise_ch());
            text.push_back(CH_RBRACE);
        end
    endtask

    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        ch <= c;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic run_phase(input int s_idle, input int r_stall, input bit long_name);
        send_idle = s_idle;
        recv_stall = r_stall;
        if (long_name)
            add_expr(1'b1);
        while (text.size() < PHASE_BEATS)
            add_expr(1'b0);
        while (text.size() > 0)
            send_byte(text.pop_front());
        push <= 1'b0;
        do
            @(posedge clk);
        while (waiting != 0);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        ch <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // operator, percent pair, largest prefix; five digits; empty name, late
        // operator, bad star; bad hex, extreme bytes, colon right before brace
        text = {CH_PLUS, CH_LA, CH_PCT, digit_ch(4), CH_UF, CH_COLON,
                CH_9, CH_9, CH_9, CH_9, CH_COMMA,
                CH_LA + 8'd1, CH_COLON, CH_1, digit_ch(2), digit_ch(3), digit_ch(4),
                digit_ch(5), CH_STAR, CH_RBRACE,
                CH_COMMA, CH_AMP, CH_STAR, CH_LA + 8'd16, CH_RBRACE,
                CH_PCT, CH_LA + 8'd6, 8'h00, 8'hFF, CH_COLON, CH_RBRACE};
        run_phase(0, 0, 1'b1);
        run_phase(66, 0, 1'b0);
        run_phase(0, 66, 1'b0);
        run_phase(36, 36, 1'b0);
        repeat (16) @(posedge clk);
        if (mismatches == 0 && waiting == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
